/* hdl/assert_macros.svh */
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked through reset as well
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/p2ch_pkg.sv */
package p2ch_pkg;

   localparam int NUM_BINS   = 100;
   localparam int COUNT_BITS = 24;
   localparam int BIN_W      = 7;
   localparam int SIDE       = NUM_BINS + 1;
   localparam int DEPTH      = SIDE * SIDE;
   localparam int AW         = $clog2(DEPTH);

   localparam logic [8:0]            NUM_BINS_W = 9'(NUM_BINS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

   localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic [30:0]        Q30_ONE     = 31'd1073741824;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [BIN_W-1:0] x;
      logic [BIN_W-1:0] y;
      logic             oob;
   } cmd_type;

   // horner divisors 156, 110, 72, 42, 20, 6, highest term first, split into
   // a power of two shifted out and an odd part done by reciprocal multiply
   function automatic logic [1:0] div_shift(input logic [2:0] i);
      logic [1:0] s;
      case (i)
         3'd0:    s = 2'd2;
         3'd1:    s = 2'd1;
         3'd2:    s = 2'd3;
         3'd3:    s = 2'd1;
         3'd4:    s = 2'd2;
         3'd5:    s = 2'd1;
         default: s = 2'd1;
      endcase
      return s;
   endfunction

   // ceil(2^k / odd part), exact for every dividend that a 32-bit value leaves after its shift
   function automatic logic [31:0] div_magic(input logic [2:0] i);
      logic [31:0] m;
      case (i)
         3'd0:    m = 32'd1762037866;
         3'd1:    m = 32'd2498890064;
         3'd2:    m = 32'd954437177;
         3'd3:    m = 32'd3272356036;
         3'd4:    m = 32'd1717986919;
         3'd5:    m = 32'd2863311531;
         default: m = 32'd2863311531;
      endcase
      return m;
   endfunction

   function automatic logic [5:0] div_post(input logic [2:0] i);
      logic [5:0] k;
      case (i)
         3'd0:    k = 6'd36;
         3'd1:    k = 6'd37;
         3'd2:    k = 6'd33;
         3'd3:    k = 6'd36;
         3'd4:    k = 6'd33;
         3'd5:    k = 6'd33;
         default: k = 6'd33;
      endcase
      return k;
   endfunction

endpackage

/* hdl/polar_to_cartesian_histogram_2d.sv */
// add beat: the angle is wrapped into range, then the shared sine unit runs twice,
// six horner terms each, with a multiply, divide and subtract step per term
// read beat: goes to the queue without conversion; one item in the converter at a time,
// a new request taken only once the last one is pushed; a two-entry queue decouples the back
// reset: synchronous, then a clearing pass over all 10201 counters, one counter a cycle,
// during which req_stall stays high
module polar_to_cartesian_histogram_2d (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic signed [15:0] req_phase,
   input  logic [15:0]       req_radius,
   input  logic [6:0]        req_read_col,
   input  logic [6:0]        req_read_row,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [6:0]        rsp_x_bin,
   output logic [6:0]        rsp_y_bin,
   output logic [23:0]       rsp_count
);

   logic              clearing;
   logic              push_valid, push_full;
   p2ch_pkg::cmd_type push_cmd, q_head;
   logic              q_pop, q_empty;

   p2ch_front u_front (
      .clock        (clock),
      .reset        (reset),
      .hold         (clearing),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_phase    (req_phase),
      .req_radius   (req_radius),
      .req_read_col (req_read_col),
      .req_read_row (req_read_row),
      .push_valid   (push_valid),
      .push_cmd     (push_cmd),
      .push_full    (push_full)
   );

   p2ch_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (push_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   p2ch_back u_back (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_x_bin (rsp_x_bin),
      .rsp_y_bin (rsp_y_bin),
      .rsp_count (rsp_count)
   );

endmodule

/* hdl/p2ch_queue.sv */
module p2ch_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  p2ch_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output p2ch_pkg::cmd_type head
);

   p2ch_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign full    = fill_ff == 2'd2;
   assign empty   = fill_ff == 2'd0;
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hdl/p2ch_front.sv */
module p2ch_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              hold,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic signed [15:0] req_phase,
   input  logic [15:0]       req_radius,
   input  logic [6:0]        req_read_col,
   input  logic [6:0]        req_read_row,
   output logic              push_valid,
   output p2ch_pkg::cmd_type push_cmd,
   input  logic              push_full
);

   typedef enum logic [10:0] {
      F_IDLE  = 11'b00000000001,
      F_WRAP  = 11'b00000000010,
      F_FOLD  = 11'b00000000100,
      F_SQR   = 11'b00000001000,
      F_MUL   = 11'b00000010000,
      F_DIV   = 11'b00000100000,
      F_SUB   = 11'b00001000000,
      F_FIN   = 11'b00010000000,
      F_COORD = 11'b00100000000,
      F_BIN   = 11'b01000000000,
      F_PUSH  = 11'b10000000000
   } fstate_type;

   fstate_type state_ff, state_in;
   logic signed [35:0] ang_ff, ang_in;
   logic signed [35:0] a_ff, a_in;
   logic        neg_ff, neg_in;
   logic [30:0] m_ff, m_in;
   logic [31:0] m2_ff, m2_in;
   logic [30:0] t_ff, t_in;
   logic [31:0] quo_ff, quo_in;
   logic [2:0]  term_ff, term_in;
   logic signed [15:0] trig_ff, trig_in;
   logic signed [32:0] v_ff, v_in;
   logic [15:0] radius_ff, radius_in;
   logic        is_sin_ff, is_sin_in;
   logic [6:0]  xb_ff, xb_in;
   p2ch_pkg::cmd_type cmd_ff, cmd_in;

   logic signed [35:0] fold;
   logic [61:0] sq_prod;
   logic [62:0] mt_prod;
   logic [61:0] fin_prod;
   logic [31:0] q_sh;
   logic [63:0] recip_prod;
   logic [31:0] recip_q;
   logic [17:0] rounded;
   logic [14:0] mag;
   logic signed [16:0] rad_s;
   logic signed [33:0] shifted;
   logic [41:0] bin_prod;
   logic [8:0]  bin_raw;
   logic [6:0]  bin;
   logic [32:0] one_minus;

   assign req_stall  = hold || (state_ff != F_IDLE);
   assign push_valid = state_ff == F_PUSH;
   assign push_cmd   = cmd_ff;

   always_comb begin
      fold = a_ff;
      if (a_ff > p2ch_pkg::Q30_HALF_PI) begin
         fold = p2ch_pkg::Q30_PI - a_ff;
      end else if (a_ff < -p2ch_pkg::Q30_HALF_PI) begin
         fold = -p2ch_pkg::Q30_PI - a_ff;
      end
      sq_prod    = 62'(m_ff) * 62'(m_ff);
      mt_prod    = 63'(m2_ff) * 63'(t_ff);
      fin_prod   = 62'(m_ff) * 62'(t_ff);
      q_sh       = quo_ff >> p2ch_pkg::div_shift(term_ff);
      recip_prod = 64'(q_sh) * 64'(p2ch_pkg::div_magic(term_ff));
      recip_q    = 32'(recip_prod >> p2ch_pkg::div_post(term_ff));
      one_minus  = 33'(p2ch_pkg::Q30_ONE) - 33'(quo_ff);
      rounded    = 18'((33'(fin_prod[61:30]) + 33'd16384) >> 15);
      mag        = (rounded > 18'd32767) ? 15'h7fff : rounded[14:0];
      rad_s      = {1'b0, radius_ff};
      shifted    = 34'(v_ff) + 34'sd2147483648;
      bin_prod   = 42'(shifted[32:0]) * 42'(p2ch_pkg::NUM_BINS_W);
      bin_raw    = bin_prod[40:32];
      bin        = (bin_raw > p2ch_pkg::NUM_BINS_W) ? 7'(p2ch_pkg::NUM_BINS) : bin_raw[6:0];
   end

   always_comb begin
      state_in  = state_ff;
      ang_in    = ang_ff;
      a_in      = a_ff;
      neg_in    = neg_ff;
      m_in      = m_ff;
      m2_in     = m2_ff;
      t_in      = t_ff;
      quo_in    = quo_ff;
      term_in   = term_ff;
      trig_in   = trig_ff;
      v_in      = v_ff;
      radius_in = radius_ff;
      is_sin_in = is_sin_ff;
      xb_in     = xb_ff;
      cmd_in    = cmd_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid && !req_stall) begin
               radius_in = req_radius;
               if (p2ch_pkg::op_type'(req_func) == p2ch_pkg::OP_READ) begin
                  cmd_in.op  = p2ch_pkg::OP_READ;
                  cmd_in.x   = req_read_col;
                  cmd_in.y   = req_read_row;
                  cmd_in.oob = (32'(req_read_col) > p2ch_pkg::NUM_BINS) ||
                               (32'(req_read_row) > p2ch_pkg::NUM_BINS);
                  state_in   = F_PUSH;
               end else begin
                  ang_in    = 36'(signed'({req_phase, 17'b0}));
                  a_in      = 36'(signed'({req_phase, 17'b0})) + p2ch_pkg::Q30_HALF_PI;
                  is_sin_in = 1'b0;
                  state_in  = F_WRAP;
               end
            end
         end
         F_WRAP: begin
            if (a_ff > p2ch_pkg::Q30_PI) begin
               a_in = a_ff - p2ch_pkg::Q30_TWO_PI;
            end else if (a_ff < -p2ch_pkg::Q30_PI) begin
               a_in = a_ff + p2ch_pkg::Q30_TWO_PI;
            end else begin
               state_in = F_FOLD;
            end
         end
         F_FOLD: begin
            neg_in   = fold < 0;
            m_in     = 31'((fold < 0) ? -fold : fold);
            state_in = F_SQR;
         end
         F_SQR: begin
            m2_in    = sq_prod[61:30];
            t_in     = p2ch_pkg::Q30_ONE;
            term_in  = 3'd0;
            state_in = F_MUL;
         end
         F_MUL: begin
            quo_in   = mt_prod[61:30];
            state_in = F_DIV;
         end
         F_DIV: begin
            // truncating divide by the term constant in one step
            quo_in   = recip_q;
            state_in = F_SUB;
         end
         F_SUB: begin
            t_in    = one_minus[30:0];
            term_in = term_ff + 3'd1;
            state_in = (term_ff == 3'd5) ? F_FIN : F_MUL;
         end
         F_FIN: begin
            trig_in  = neg_ff ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
            state_in = F_COORD;
         end
         F_COORD: begin
            v_in     = rad_s * trig_ff;
            state_in = F_BIN;
         end
         F_BIN: begin
            if (!is_sin_ff) begin
               xb_in     = bin;
               is_sin_in = 1'b1;
               a_in      = ang_ff;
               state_in  = F_WRAP;
            end else begin
               cmd_in.op  = p2ch_pkg::OP_ADD;
               cmd_in.x   = xb_ff;
               cmd_in.y   = bin;
               cmd_in.oob = 1'b0;
               state_in   = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!push_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ang_ff    <= ang_in;
      a_ff      <= a_in;
      neg_ff    <= neg_in;
      m_ff      <= m_in;
      m2_ff     <= m2_in;
      t_ff      <= t_in;
      quo_ff    <= quo_in;
      term_ff   <= term_in;
      trig_ff   <= trig_in;
      v_ff      <= v_in;
      radius_ff <= radius_in;
      is_sin_ff <= is_sin_in;
      xb_ff     <= xb_in;
      cmd_ff    <= cmd_in;
   end

endmodule

/* hdl/p2ch_back.sv */
module p2ch_back (
   input  logic              clock,
   input  logic              reset,
   output logic              clearing,
   input  logic              q_empty,
   input  p2ch_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [6:0]        rsp_x_bin,
   output logic [6:0]        rsp_y_bin,
   output logic [23:0]       rsp_count
);

   typedef enum logic [4:0] {
      B_CLEAR = 5'b00001,
      B_IDLE  = 5'b00010,
      B_READ  = 5'b00100,
      B_UPD   = 5'b01000,
      B_OUT   = 5'b10000
   } bstate_type;

   localparam int CW = p2ch_pkg::COUNT_BITS;
   localparam int AW = p2ch_pkg::AW;

   logic [CW-1:0] mem [p2ch_pkg::DEPTH];

   bstate_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] addr_ff, addr_in;
   p2ch_pkg::cmd_type cmd_ff, cmd_in;
   logic [CW-1:0] rdata_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [6:0]    x_ff, x_in, y_ff, y_in;
   logic          we;
   logic [AW-1:0] waddr;
   logic [CW-1:0] wdata;
   logic [CW-1:0] upd;

   assign clearing  = state_ff == B_CLEAR;
   assign rsp_valid = state_ff == B_OUT;
   assign rsp_x_bin = x_ff;
   assign rsp_y_bin = y_ff;
   assign rsp_count = count_ff;
   assign q_pop     = (state_ff == B_IDLE) && !q_empty;

   always_comb begin
      upd = (rdata_ff == p2ch_pkg::COUNT_MAX) ? rdata_ff : rdata_ff + CW'(1);
      state_in = state_ff;
      clr_in   = clr_ff;
      addr_in  = addr_ff;
      cmd_in   = cmd_ff;
      count_in = count_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      we       = 1'b0;
      waddr    = addr_ff;
      wdata    = upd;
      case (state_ff)
         B_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            wdata  = '0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(p2ch_pkg::DEPTH - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_empty) begin
               cmd_in  = q_head;
               addr_in = q_head.oob ? '0 :
                         AW'(AW'(q_head.x) * AW'(p2ch_pkg::SIDE) + AW'(q_head.y));
               state_in = B_READ;
            end
         end
         B_READ: begin
            state_in = B_UPD;
         end
         B_UPD: begin
            x_in = cmd_ff.x;
            y_in = cmd_ff.y;
            if (cmd_ff.op == p2ch_pkg::OP_ADD) begin
               we       = 1'b1;
               count_in = upd;
            end else begin
               count_in = cmd_ff.oob ? '0 : rdata_ff;
            end
            state_in = B_OUT;
         end
         B_OUT: begin
            if (!rsp_stall) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      cmd_ff   <= cmd_in;
      count_ff <= count_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[addr_ff];
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

endmodule

/* hdl/p2ch_checker.sv */
`include "assert_macros.svh"

module p2ch_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_func,
   input logic signed [15:0] req_phase,
   input logic [15:0]       req_radius,
   input logic [6:0]        req_read_col,
   input logic [6:0]        req_read_row,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [6:0]        rsp_x_bin,
   input logic [6:0]        rsp_y_bin,
   input logic [23:0]       rsp_count
);

   // a stalled result beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_count) && $stable(rsp_x_bin) && $stable(rsp_y_bin))

   // the clearing pass keeps the input closed straight after reset
   `ASSERT_NEXT_ALWAYS(a_clear_stall, clock, reset, req_stall && !rsp_valid)

   // a nonzero count can only come from a bin inside the histogram
   `ASSERT_SAME(a_count_in_range, clock, reset, rsp_valid && (rsp_count != 24'd0), (rsp_x_bin <= 7'd100) && (rsp_y_bin <= 7'd100))

   // an accepted beat closes the input until its work is done
   `ASSERT_NEXT(a_accept_closes, clock, reset, req_valid && !req_stall, req_stall)

endmodule

bind polar_to_cartesian_histogram_2d p2ch_checker u_chk (.*);

/* verif/polar_to_cartesian_histogram_2d_tb.sv */
`timescale 1ns / 100ps

module polar_to_cartesian_histogram_2d_tb;

   typedef struct {
      p2ch_pkg::op_type op;
      logic [15:0] phase;
      logic [15:0] radius;
      logic [6:0]  col;
      logic [6:0]  row;
      bit          typed;
      logic [6:0]  x_exp;
      logic [6:0]  y_exp;
      logic [23:0] count_exp;
   } sample_row;

   typedef struct {
      logic [6:0]  x_bin;
      logic [6:0]  y_bin;
      logic [23:0] count;
   } bin_result;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_func = 1'b0;
   logic signed [15:0] req_phase = '0;
   logic [15:0]       req_radius = '0;
   logic [6:0]        req_read_col = '0;
   logic [6:0]        req_read_row = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [6:0]        rsp_x_bin;
   logic [6:0]        rsp_y_bin;
   logic [23:0]       rsp_count;

   int unsigned bin_counts [0:p2ch_pkg::DEPTH-1];
   bin_result   pending_bins[$];
   int          fails = 0;
   bit          calm = 1'b0;
   logic [6:0]  last_x = 7'd50;
   logic [6:0]  last_y = 7'd50;

   polar_to_cartesian_histogram_2d dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #15_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // sine of a q30 angle, result in q1.15
   function automatic int q15_sine(longint a);
      longint unsigned m, m2, t, s;
      bit neg;
      longint unsigned divs [6] = '{156, 110, 72, 42, 20, 6};
      if (a > p2ch_pkg::Q30_PI) a -= p2ch_pkg::Q30_TWO_PI;
      if (a > p2ch_pkg::Q30_PI) a -= p2ch_pkg::Q30_TWO_PI;
      if (a < -p2ch_pkg::Q30_PI) a += p2ch_pkg::Q30_TWO_PI;
      if (a < -p2ch_pkg::Q30_PI) a += p2ch_pkg::Q30_TWO_PI;
      if (a > p2ch_pkg::Q30_HALF_PI) a = p2ch_pkg::Q30_PI - a;
      if (a < -p2ch_pkg::Q30_HALF_PI) a = -p2ch_pkg::Q30_PI - a;
      neg = a < 0;
      m = neg ? longint'(-a) : longint'(a);
      m2 = (m * m) >> 30;
      t = p2ch_pkg::Q30_ONE;
      for (int i = 0; i < 6; i++)
         t = longint'(p2ch_pkg::Q30_ONE) - ((m2 * t) >> 30) / divs[i];
      s = (m * t) >> 30;
      s = (s + 16384) >> 15;
      if (s > 32767) s = 32767;
      return neg ? -int'(s) : int'(s);
   endfunction

   function automatic logic [6:0] coord_bin(logic [15:0] r, int trig);
      longint v;
      longint unsigned b;
      v = longint'(r) * longint'(trig);
      b = (longint'(v + 64'sd2147483648) * p2ch_pkg::NUM_BINS) >> 32;
      if (b > p2ch_pkg::NUM_BINS) b = p2ch_pkg::NUM_BINS;
      return 7'(b);
   endfunction

   function automatic bin_result bin_update(sample_row s);
      bin_result res;
      longint ang;
      int idx;
      if (s.op == p2ch_pkg::OP_ADD) begin
         ang = longint'($signed(s.phase)) * 131072;
         res.x_bin = coord_bin(s.radius, q15_sine(ang + p2ch_pkg::Q30_HALF_PI));
         res.y_bin = coord_bin(s.radius, q15_sine(ang));
         idx = res.x_bin * p2ch_pkg::SIDE + res.y_bin;
         if (bin_counts[idx] < p2ch_pkg::COUNT_MAX) bin_counts[idx]++;
         res.count = 24'(bin_counts[idx]);
      end else begin
         res.x_bin = s.col;
         res.y_bin = s.row;
         if (s.col <= p2ch_pkg::NUM_BINS && s.row <= p2ch_pkg::NUM_BINS)
            res.count = 24'(bin_counts[s.col * p2ch_pkg::SIDE + s.row]);
         else
            res.count = '0;
      end
      return res;
   endfunction

   task automatic send_beat(sample_row s);
      bin_result res;
      while (!calm && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= s.op;
      req_phase    <= s.phase;
      req_radius   <= s.radius;
      req_read_col <= s.col;
      req_read_row <= s.row;
      do @(posedge clock); while (req_stall);
      res = bin_update(s);
      if (s.typed && (res.x_bin !== s.x_exp || res.y_bin !== s.y_exp ||
            res.count !== s.count_exp)) begin
         res.x_bin = s.x_exp;
         res.y_bin = s.y_exp;
         res.count = s.count_exp;
      end
      if (s.op == p2ch_pkg::OP_ADD) begin
         last_x = res.x_bin;
         last_y = res.y_bin;
      end
      pending_bins.push_back(res);
      @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_stall <= !calm && $urandom_range(99) < 21;

   always @(posedge clock) begin
      bin_result want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bins.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected beat x=%0d y=%0d count=%0d",
               rsp_x_bin, rsp_y_bin, rsp_count);
         end else begin
            want = pending_bins.pop_front();
            if (rsp_x_bin !== want.x_bin || rsp_y_bin !== want.y_bin ||
                  rsp_count !== want.count) begin
               fails++;
               if (fails <= 10)
                  $display("mismatch: expected x=%0d y=%0d count=%0d, got x=%0d y=%0d count=%0d",
                     want.x_bin, want.y_bin, want.count, rsp_x_bin, rsp_y_bin, rsp_count);
            end
         end
      end
   end

   function automatic sample_row add_row(logic [15:0] ph, logic [15:0] r);
      sample_row s;
      s = '{p2ch_pkg::OP_ADD, ph, r, 7'd0, 7'd0, 1'b0, 7'd0, 7'd0, 24'd0};
      return s;
   endfunction

   function automatic sample_row read_row(logic [6:0] c, logic [6:0] r, bit typed,
                                          logic [23:0] cnt);
      sample_row s;
      s = '{p2ch_pkg::OP_READ, 16'd0, 16'd0, c, r, typed, c, r, cnt};
      return s;
   endfunction

   initial begin
      sample_row directed[$];
      sample_row s;
      for (int i = 0; i < p2ch_pkg::DEPTH; i++) bin_counts[i] = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty histogram, corners and reads past the edge
      directed.push_back(read_row(7'd0, 7'd0, 1, 24'd0));
      directed.push_back(read_row(7'd100, 7'd100, 1, 24'd0));
      directed.push_back(read_row(7'd101, 7'd0, 1, 24'd0));
      directed.push_back(read_row(7'd0, 7'd127, 1, 24'd0));
      directed.push_back(read_row(7'd127, 7'd127, 1, 24'd0));
      // origin lands in the centre bin; then full radius along the axes
      directed.push_back(add_row(16'd0, 16'd0));
      directed.push_back(add_row(16'd0, 16'd0));
      directed.push_back(add_row(16'd0, 16'hFFFF));
      directed.push_back(add_row(16'sd25736, 16'hFFFF));
      directed.push_back(add_row(-16'sd25736, 16'hFFFF));
      directed.push_back(add_row(16'sd12868, 16'hFFFF));
      directed.push_back(add_row(-16'sd12868, 16'hFFFF));
      // angles beyond pi wrap round
      directed.push_back(add_row(16'h7FFF, 16'hFFFF));
      directed.push_back(add_row(16'h8000, 16'hFFFF));
      directed.push_back(add_row(16'h8000, 16'h8000));
      directed.push_back(add_row(16'h5555, 16'hAAAA));
      directed.push_back(add_row(16'hAAAA, 16'h5555));
      directed.push_back(read_row(7'd50, 7'd50, 0, 24'd0));
      directed.push_back(read_row(7'd99, 7'd50, 0, 24'd0));
      directed.push_back(read_row(7'd0, 7'd50, 0, 24'd0));
      directed.push_back(read_row(7'd50, 7'd99, 0, 24'd0));
      directed.push_back(read_row(7'd42, 7'd85, 0, 24'd0));

      @(negedge clock);
      foreach (directed[i]) send_beat(directed[i]);

      for (int n = 0; n < 530; n++) begin
         calm = (n >= 200 && n < 300);
         if (n == 350) begin
            req_valid <= 1'b0;
            wait (pending_bins.size() == 0);
            @(negedge clock);
         end
         if ($urandom_range(99) < 70) begin
            // small radii crowd the centre so bins fill up
            s = add_row(16'($urandom), $urandom_range(3) == 0 ?
               16'($urandom_range(4000)) : 16'($urandom));
         end else if ($urandom_range(3) != 0) begin
            s = read_row(last_x, last_y, 0, 24'd0);
         end else begin
            s = read_row(7'($urandom_range(127)), 7'($urandom_range(127)), 0, 24'd0);
         end
         send_beat(s);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      wait (pending_bins.size() == 0);
      repeat (40) @(posedge clock);
      if (fails == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
